// ----- hdl/run_length_histogram_miner_assert.svh -----
// ----------------------------------------------------------------------------
// Run-length histogram miner: assertion macros
// Wraps concurrent assertions so that synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_HISTOGRAM_MINER_ASSERT_SVH
`define RUN_LENGTH_HISTOGRAM_MINER_ASSERT_SVH

`ifndef SYNTHESIS
`define RLHM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlhm assertion failed");
`define RLHM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlhm assertion failed");
`else
`define RLHM_ASSERT_IMP(lbl, ante, cons)
`define RLHM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/rlhm_pkg.sv -----
// ----------------------------------------------------------------------------
// rlhm_pkg
// Shared constants, request codes and control structs of the histogram miner.
// ----------------------------------------------------------------------------
package rlhm_pkg;

  localparam int DEF_MAX_BINS    = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int COMP_W  = 32;
  localparam int COUNT_W = 32;
  localparam int RUN_W   = 6;
  localparam int BIDX_W  = 6;
  localparam int TDATA_W = 104;
  localparam int CFG_W   = 6;

  localparam logic [RUN_W-1:0]   RUN_CAP       = 6'd63;
  localparam logic [RUN_W-1:0]   MAX_RUN_RESET = 6'd15;
  localparam logic [COUNT_W-1:0] COUNT_FULL    = 32'hFFFF_FFFF;

  // request kinds
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // compared component
  localparam logic [1:0] COL_A = 2'd0;
  localparam logic [1:0] COL_B = 2'd1;

  // register indexes
  localparam logic CFG_COLUMN_SELECT = 1'b0;
  localparam logic CFG_MAX_RUN       = 1'b1;

  typedef struct packed {
    logic       mem_bump;   // one bin at index >= 1 gets incremented
    logic [1:0] bin0_inc;   // increments for bin 0 (0..2)
  } run_close_t;

  typedef struct packed {
    logic       push_mem;
    logic [1:0] bin0_inc;
    logic       read;
    logic       read_bin0;
    logic       read_zero;
    logic       clear;
  } bin_cmd_t;

endpackage

// ----- hdl/run_length_histogram_miner.sv -----
// ----------------------------------------------------------------------------
// run_length_histogram_miner
// Histogram of run lengths over a stream of tuples, with read and clear.
// ----------------------------------------------------------------------------
// The block takes one request per cycle. A push closes at most two runs; the
// bin above zero is updated through a two-stage RAM read-modify-write with
// forwarding, bin 0 sits in its own register. A read returns its bin count
// on m_tdata through the s1, s2 and output registers. Input stalls only
// while a read result waits in the output register and a second read result
// is ready behind it. Reset and clear empty the histogram at once through
// per-bin valid bits; there is no clearing pass.
module run_length_histogram_miner #(
  parameter int MAX_BINS    = rlhm_pkg::DEF_MAX_BINS,
  parameter int VALUE_WIDTH = rlhm_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // comp_a[31:0], comp_b[63:32], comp_c[95:64], bin_index[101:96], zero pad
  input  logic [rlhm_pkg::TDATA_W-1:0]  s_tdata,
  // req_type[1:0]
  input  logic [1:0]                    s_tuser,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // bin_count[31:0]
  output logic [rlhm_pkg::COUNT_W-1:0]  m_tdata,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rlhm_pkg::CFG_W-1:0]    cfg_data
);
  import rlhm_pkg::*;

  localparam int BinW = $clog2(MAX_BINS);

  logic [1:0]       column_select;
  logic [RUN_W-1:0] max_run;

  logic                     s1_valid;
  logic [1:0]               s1_req;
  logic signed [COMP_W-1:0] s1_comp_a;
  logic signed [COMP_W-1:0] s1_comp_b;
  logic signed [COMP_W-1:0] s1_comp_c;
  logic                     s1_last;
  logic [BIDX_W-1:0]        s1_bin_index;

  logic               en;
  logic               push;
  logic               clear;
  logic               read;
  run_close_t         close;
  logic [BinW-1:0]    close_addr;
  bin_cmd_t           cmd;
  logic [BinW-1:0]    addr;
  logic               res_valid;
  logic [COUNT_W-1:0] res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_select <= COL_A;
      max_run       <= MAX_RUN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMN_SELECT: column_select <= cfg_data[1:0];
        CFG_MAX_RUN:       max_run       <= cfg_data[RUN_W-1:0];
        default:           ;
      endcase
    end
  end

  assign en       = !(res_valid && m_tvalid && !m_tready);
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s_tvalid) begin
      s1_req       <= s_tuser;
      s1_comp_a    <= s_tdata[31:0];
      s1_comp_b    <= s_tdata[63:32];
      s1_comp_c    <= s_tdata[95:64];
      s1_last      <= s_tlast;
      s1_bin_index <= s_tdata[101:96];
    end
  end

  assign push  = s1_valid && (s1_req == REQ_PUSH);
  assign read  = s1_valid && (s1_req == REQ_READ);
  assign clear = s1_valid && (s1_req == REQ_CLEAR);

  rlhm_run_tracker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_BINS    (MAX_BINS)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .push          (push),
    .clear         (clear),
    .column_select (column_select),
    .max_run       (max_run),
    .comp_a        (s1_comp_a),
    .comp_b        (s1_comp_b),
    .comp_c        (s1_comp_c),
    .row_last      (s1_last),
    .close         (close),
    .bin_addr      (close_addr)
  );

  always_comb begin
    cmd.push_mem  = close.mem_bump;
    cmd.bin0_inc  = close.bin0_inc;
    cmd.read      = read;
    cmd.read_bin0 = s1_bin_index == '0;
    cmd.read_zero = int'(s1_bin_index) >= MAX_BINS;
    cmd.clear     = clear;
    addr          = read ? BinW'(s1_bin_index) : close_addr;
  end

  rlhm_bin_store #(
    .MAX_BINS (MAX_BINS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cmd       (cmd),
    .addr      (addr),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && res_valid) begin
      m_tdata <= res_data;
    end
  end

`include "run_length_histogram_miner_assert.svh"

  `RLHM_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid && !m_tready && res_valid)
  `RLHM_ASSERT_NXT(a_clear_no_result, clear && en, !res_valid)
  `RLHM_ASSERT_IMP(a_result_loaded, $rose(m_tvalid), $past(res_valid) && $past(en))

endmodule

// ----- hdl/rlhm_run_tracker.sv -----
// ----------------------------------------------------------------------------
// rlhm_run_tracker
// Tracks the open run of equal values and reports which bins a push closes.
// ----------------------------------------------------------------------------
module rlhm_run_tracker #(
  parameter int VALUE_WIDTH = rlhm_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_BINS    = rlhm_pkg::DEF_MAX_BINS,
  localparam int BinW       = $clog2(MAX_BINS)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             push,
  input  logic                             clear,
  input  logic [1:0]                       column_select,
  input  logic [rlhm_pkg::RUN_W-1:0]       max_run,
  input  logic signed [rlhm_pkg::COMP_W-1:0] comp_a,
  input  logic signed [rlhm_pkg::COMP_W-1:0] comp_b,
  input  logic signed [rlhm_pkg::COMP_W-1:0] comp_c,
  input  logic                             row_last,
  output rlhm_pkg::run_close_t             close,
  output logic [BinW-1:0]                  bin_addr
);
  import rlhm_pkg::*;

  logic [VALUE_WIDTH-1:0] prev_value;
  logic [VALUE_WIDTH-1:0] prev_value_next;
  logic [RUN_W-1:0]       run_length;
  logic [RUN_W-1:0]       run_length_next;
  logic                   run_open;
  logic                   run_open_next;

  logic [COMP_W-1:0]   sel;
  logic [63:0]         sel_ext;
  logic [VALUE_WIDTH-1:0] v;
  logic                differ;
  logic                continuing;
  logic [RUN_W-1:0]    len_mid;
  logic                close_end;
  logic [RUN_W-1:0]    mem_len;
  logic [1:0]          inc0;

  always_comb begin
    unique case (column_select)
      COL_A:   sel = comp_a;
      COL_B:   sel = comp_b;
      default: sel = comp_c;
    endcase
    sel_ext = {{(64 - COMP_W){sel[COMP_W-1]}}, sel};
    v       = sel_ext[VALUE_WIDTH-1:0];

    differ     = run_open && (v != prev_value);
    continuing = run_open && !differ;
    if (continuing) begin
      len_mid = (run_length == RUN_CAP) ? run_length : run_length + 1'b1;
    end else begin
      len_mid = '0;
    end
    close_end = (len_mid >= max_run) || row_last;

    // A run opened by this push can only close at length zero, so at most one
    // bump lands above bin 0 per push.
    mem_len = differ ? run_length : len_mid;
    if (int'(mem_len) >= MAX_BINS) begin
      bin_addr = BinW'(MAX_BINS - 1);
    end else begin
      bin_addr = BinW'(mem_len);
    end

    inc0 = 2'(differ && (run_length == '0)) + 2'(close_end && !continuing);
    close.mem_bump = push && ((differ && (run_length != '0)) || (close_end && continuing));
    close.bin0_inc = push ? inc0 : 2'd0;

    run_open_next   = !close_end;
    run_length_next = close_end ? '0 : len_mid;
    prev_value_next = continuing ? prev_value : v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_value <= '0;
      run_length <= '0;
      run_open   <= 1'b0;
    end else if (en) begin
      if (clear) begin
        prev_value <= '0;
        run_length <= '0;
        run_open   <= 1'b0;
      end else if (push) begin
        prev_value <= prev_value_next;
        run_length <= run_length_next;
        run_open   <= run_open_next;
      end
    end
  end

endmodule

// ----- hdl/rlhm_bin_store.sv -----
// ----------------------------------------------------------------------------
// rlhm_bin_store
// Histogram bins: bin 0 in a register, the rest in a RAM with read-modify-
// write, per-entry valid bits and forwarding of the last write.
// ----------------------------------------------------------------------------
module rlhm_bin_store #(
  parameter int MAX_BINS = rlhm_pkg::DEF_MAX_BINS,
  localparam int BinW    = $clog2(MAX_BINS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  rlhm_pkg::bin_cmd_t            cmd,
  input  logic [BinW-1:0]               addr,
  output logic                          res_valid,
  output logic [rlhm_pkg::COUNT_W-1:0]  res_data
);
  import rlhm_pkg::*;

  logic [COUNT_W-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0] valid;

  logic [COUNT_W-1:0] bin0;
  logic [COUNT_W:0]   bin0_sum;
  logic [COUNT_W-1:0] bin0_next;

  logic [COUNT_W-1:0] rd_data;
  logic               rd_valid;

  logic               s2_bump;
  logic               s2_read;
  logic               s2_use_mem;
  logic [BinW-1:0]    s2_addr;
  logic [COUNT_W-1:0] s2_direct;

  logic               last_wr_en;
  logic [BinW-1:0]    last_wr_addr;
  logic [COUNT_W-1:0] last_wr_val;

  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] bumped;

  always_comb begin
    bin0_sum  = {1'b0, bin0} + (COUNT_W + 1)'(cmd.bin0_inc);
    bin0_next = bin0_sum[COUNT_W] ? COUNT_FULL : bin0_sum[COUNT_W-1:0];

    // the write at the edge that launched this read is not in rd_data yet
    if (last_wr_en && (last_wr_addr == s2_addr)) begin
      base = last_wr_val;
    end else if (rd_valid) begin
      base = rd_data;
    end else begin
      base = '0;
    end
    bumped    = (base == COUNT_FULL) ? base : base + 1'b1;
    res_valid = s2_read;
    res_data  = s2_use_mem ? base : s2_direct;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= mem[addr];
      if (s2_bump) begin
        mem[s2_addr] <= bumped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      bin0       <= '0;
      rd_valid   <= 1'b0;
      s2_bump    <= 1'b0;
      s2_read    <= 1'b0;
      last_wr_en <= 1'b0;
    end else if (en) begin
      rd_valid   <= valid[addr];
      s2_bump    <= cmd.push_mem;
      s2_read    <= cmd.read;
      last_wr_en <= s2_bump && !cmd.clear;
      if (cmd.clear) begin
        valid <= '0;
        bin0  <= '0;
      end else begin
        bin0 <= bin0_next;
        if (s2_bump) begin
          valid[s2_addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_addr      <= addr;
      s2_use_mem   <= !cmd.read_bin0 && !cmd.read_zero;
      s2_direct    <= cmd.read_zero ? '0 : bin0;
      last_wr_addr <= s2_addr;
      last_wr_val  <= bumped;
    end
  end

endmodule
